>>> rtl/bbaq_pkg.sv
`timescale 1ns / 1ps

package bbaq_pkg;

    localparam int unsigned COORD_W  = 20;
    localparam int unsigned SQ_W     = 2 * COORD_W;
    localparam int unsigned DIST_W   = 42;
    localparam int unsigned MAX_DIMS = 4;

    localparam logic [COORD_W-1:0] COORD_MAX = COORD_W'(1000000);

    typedef enum logic [2:0] {
        OP_CLEAR       = 3'd0,
        OP_LOAD        = 3'd1,
        OP_GROW_POINT  = 3'd2,
        OP_GROW_BOX    = 3'd3,
        OP_CONTAINS    = 3'd4,
        OP_STRICT      = 3'd5,
        OP_OVERLAPS    = 3'd6,
        OP_DISTANCE    = 3'd7
    } op_t;

    typedef struct packed {
        op_t                operation;
        logic [COORD_W-1:0] point_or_low_0;
        logic [COORD_W-1:0] point_or_low_1;
        logic [COORD_W-1:0] point_or_low_2;
        logic [COORD_W-1:0] point_or_low_3;
        logic [COORD_W-1:0] upper_edge_0;
        logic [COORD_W-1:0] upper_edge_1;
        logic [COORD_W-1:0] upper_edge_2;
        logic [COORD_W-1:0] upper_edge_3;
    } in_item_t;

    typedef struct packed {
        logic              test_true;
        logic [DIST_W-1:0] distance_squared;
    } out_item_t;

    // Per-cycle control handed from the top level to every lane.
    typedef struct packed {
        logic accept;
        op_t  op;
        logic load_s1;
        logic load_s2;
    } lane_ctl_t;

    // What one lane found for the query in its second stage.
    typedef struct packed {
        logic            contains_ok;
        logic            strict_ok;
        logic            overlap_ok;
        logic [SQ_W-1:0] gap_sq;
    } lane_res_t;

    function automatic logic [COORD_W-1:0] sat_coord(input logic [COORD_W-1:0] v);
        return (v > COORD_MAX) ? COORD_MAX : v;
    endfunction

    function automatic logic [COORD_W-1:0] pick_low(input in_item_t it,
                                                    input int unsigned idx);
        logic [COORD_W-1:0] r;
        unique case (idx)
            0:       r = it.point_or_low_0;
            1:       r = it.point_or_low_1;
            2:       r = it.point_or_low_2;
            default: r = it.point_or_low_3;
        endcase
        return r;
    endfunction

    function automatic logic [COORD_W-1:0] pick_high(input in_item_t it,
                                                     input int unsigned idx);
        logic [COORD_W-1:0] r;
        unique case (idx)
            0:       r = it.upper_edge_0;
            1:       r = it.upper_edge_1;
            2:       r = it.upper_edge_2;
            default: r = it.upper_edge_3;
        endcase
        return r;
    endfunction

endpackage

>>> rtl/bbaq_lane.sv
`timescale 1ns / 1ps

module bbaq_lane (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  bbaq_pkg::lane_ctl_t         ctl,
    input  logic [bbaq_pkg::COORD_W-1:0] raw_low,
    input  logic [bbaq_pkg::COORD_W-1:0] raw_high,
    output bbaq_pkg::lane_res_t         res
);
    import bbaq_pkg::*;

    logic [COORD_W-1:0] box_low_reg,  box_low_next;
    logic [COORD_W-1:0] box_high_reg, box_high_next;
    logic [COORD_W-1:0] pl, ph;

    logic               contains_now, strict_now, overlap_now;
    logic [COORD_W-1:0] gap_now;

    logic               contains_s1_reg, strict_s1_reg, overlap_s1_reg;
    logic [COORD_W-1:0] gap_s1_reg;
    lane_res_t          res_reg;

    assign pl = sat_coord(raw_low);
    assign ph = sat_coord(raw_high);

    always_comb begin
        box_low_next  = box_low_reg;
        box_high_next = box_high_reg;
        if (ctl.accept) begin
            unique case (ctl.op)
                OP_CLEAR: begin
                    box_low_next  = COORD_MAX;
                    box_high_next = '0;
                end
                OP_LOAD: begin
                    box_low_next  = pl;
                    box_high_next = ph;
                end
                OP_GROW_POINT: begin
                    if (pl < box_low_reg)  box_low_next  = pl;
                    if (pl > box_high_reg) box_high_next = pl;
                end
                OP_GROW_BOX: begin
                    if (pl < box_low_reg)  box_low_next  = pl;
                    if (ph > box_high_reg) box_high_next = ph;
                end
                default: begin
                end
            endcase
        end
    end

    // Queries look at the box as it stood before this item.
    always_comb begin
        contains_now = !(pl < box_low_reg || pl > box_high_reg);
        strict_now   = (box_low_reg < pl) && (pl < box_high_reg);
        overlap_now  = !(box_high_reg < pl || ph < box_low_reg);
        if (pl < box_low_reg) begin
            gap_now = box_low_reg - pl;
        end else if (pl > box_high_reg) begin
            gap_now = pl - box_high_reg;
        end else begin
            gap_now = '0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            box_low_reg  <= COORD_MAX;
            box_high_reg <= '0;
        end else begin
            box_low_reg  <= box_low_next;
            box_high_reg <= box_high_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (ctl.load_s1) begin
            contains_s1_reg <= contains_now;
            strict_s1_reg   <= strict_now;
            overlap_s1_reg  <= overlap_now;
            gap_s1_reg      <= gap_now;
        end
        if (ctl.load_s2) begin
            res_reg.contains_ok <= contains_s1_reg;
            res_reg.strict_ok   <= strict_s1_reg;
            res_reg.overlap_ok  <= overlap_s1_reg;
            res_reg.gap_sq      <= gap_s1_reg * gap_s1_reg;
        end
    end

    assign res = res_reg;

endmodule

>>> rtl/bbaq_merge.sv
`timescale 1ns / 1ps

module bbaq_merge #(
    parameter int unsigned DIMENSIONS = bbaq_pkg::MAX_DIMS
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  bbaq_pkg::lane_res_t  res [DIMENSIONS],
    input  bbaq_pkg::op_t        op,
    input  logic                 in_valid,
    output logic                 out_free,
    output logic                 m_valid,
    input  logic                 m_ready,
    output bbaq_pkg::out_item_t  m_item
);
    import bbaq_pkg::*;

    logic              m_valid_reg;
    out_item_t         m_item_reg, m_item_next;
    logic              all_contains, all_strict, all_overlap;
    logic [DIST_W-1:0] dist_sum;

    assign out_free = !m_valid_reg || m_ready;

    always_comb begin
        all_contains = 1'b1;
        all_strict   = 1'b1;
        all_overlap  = 1'b1;
        dist_sum     = '0;
        for (int unsigned d = 0; d < DIMENSIONS; d++) begin
            all_contains = all_contains & res[d].contains_ok;
            all_strict   = all_strict   & res[d].strict_ok;
            all_overlap  = all_overlap  & res[d].overlap_ok;
            dist_sum     = dist_sum + DIST_W'(res[d].gap_sq);
        end
    end

    always_comb begin
        m_item_next.test_true        = 1'b0;
        m_item_next.distance_squared = '0;
        unique case (op)
            OP_CONTAINS: m_item_next.test_true        = all_contains;
            OP_STRICT:   m_item_next.test_true        = all_strict;
            OP_OVERLAPS: m_item_next.test_true        = all_overlap;
            OP_DISTANCE: m_item_next.distance_squared = dist_sum;
            default: begin
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (out_free) begin
            m_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (out_free && in_valid) begin
            m_item_reg <= m_item_next;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_item  = m_item_reg;

endmodule

>>> rtl/bounding_box_accumulate_and_query.sv
`timescale 1ns / 1ps

// Keeps one axis-aligned box of DIMENSIONS dimensions (one to four) and applies one
// operation per item: clear, load, grow by a point or box, containment and overlap
// tests, and squared distance from a point. Coordinates above 1000000 are saturated.
// Each dimension has its own lane holding its edges, so an item is accepted every
// cycle unless a held-back output has filled the stages; box changes take effect for
// the very next item. Query items give one result each, registered in turn through
// compare and gap, square, and the sum across lanes into the output register;
// set-up items give none. The stages stall when the output is held back.
module bounding_box_accumulate_and_query #(
    parameter int unsigned DIMENSIONS = bbaq_pkg::MAX_DIMS
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  bbaq_pkg::in_item_t  s_item,
    output logic                m_valid,
    input  logic                m_ready,
    output bbaq_pkg::out_item_t m_item
);
    import bbaq_pkg::*;

    logic      v1_reg, v2_reg;
    op_t       op1_reg, op2_reg;
    logic      take1, take2, out_free, accept, is_query;
    lane_ctl_t ctl;
    lane_res_t res [DIMENSIONS];

    assign take2   = !v2_reg || out_free;
    assign take1   = !v1_reg || take2;
    assign s_ready = take1;
    assign accept  = s_valid && take1;

    assign is_query = (s_item.operation == OP_CONTAINS) || (s_item.operation == OP_STRICT)
                   || (s_item.operation == OP_OVERLAPS) || (s_item.operation == OP_DISTANCE);

    assign ctl.accept  = accept;
    assign ctl.op      = s_item.operation;
    assign ctl.load_s1 = take1;
    assign ctl.load_s2 = take2;

    for (genvar g = 0; g < DIMENSIONS; g++) begin : g_lane
        bbaq_lane u_lane (
            .aclk     (aclk),
            .aresetn  (aresetn),
            .ctl      (ctl),
            .raw_low  (pick_low(s_item, g)),
            .raw_high (pick_high(s_item, g)),
            .res      (res[g])
        );
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
        end else begin
            if (take1) v1_reg <= accept && is_query;
            if (take2) v2_reg <= v1_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (take1) op1_reg <= s_item.operation;
        if (take2) op2_reg <= op1_reg;
    end

    bbaq_merge #(
        .DIMENSIONS (DIMENSIONS)
    ) u_merge (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .res      (res),
        .op       (op2_reg),
        .in_valid (v2_reg),
        .out_free (out_free),
        .m_valid  (m_valid),
        .m_ready  (m_ready),
        .m_item   (m_item)
    );

endmodule

>>> tb/sv/tb_bounding_box_accumulate_and_query.sv
`timescale 1ns / 1ps

module tb_bounding_box_accumulate_and_query;

    import bbaq_pkg::*;

    localparam int unsigned DIMS        = 4;
    localparam int          CYCLE_LIMIT = 200000;
    localparam int          LONG_HOLD   = 300;
    localparam int          SETTLE      = 8;
    localparam logic [DIST_W-1:0] FAR_CORNER = 42'd4000000000000;

    typedef struct {
        in_item_t  item;
        bit        pinned;
        out_item_t res;
    } dir_row_t;

    logic      aclk    = 1'b0;
    logic      aresetn = 1'b0;
    logic      s_valid = 1'b0;
    logic      s_ready;
    in_item_t  s_item  = '0;
    logic      m_valid;
    logic      m_ready = 1'b0;
    out_item_t m_item;

    // Typed-in answer for the item currently offered, if the table gives one.
    bit        pinned_ok  = 1'b0;
    out_item_t pinned_res = '0;

    logic [COORD_W-1:0] box_lo [DIMS];
    logic [COORD_W-1:0] box_hi [DIMS];
    out_item_t          pending_answers [$];
    dir_row_t           rows [$];

    int send_idle_pct  = 0;
    int recv_stall_pct = 0;
    int hold_requests  = 0;
    int hold_served    = 0;
    int hold_left      = 0;
    int cycle_count    = 0;
    int errors         = 0;
    int results_seen   = 0;
    int op_seen [8];

    bounding_box_accumulate_and_query #(
        .DIMENSIONS(DIMS)
    ) dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_item  (s_item),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_item  (m_item)
    );

    always #6 aclk = ~aclk;

    function automatic logic [COORD_W-1:0] clamp_coord(input logic [COORD_W-1:0] v);
        return (v > COORD_MAX) ? COORD_MAX : v;
    endfunction

    // Applies one item to the local copy of the box; returns 1 when it yields an answer.
    function automatic bit apply_box_op(input in_item_t it, output out_item_t res);
        logic [COORD_W-1:0] pl [4];
        logic [COORD_W-1:0] ph [4];
        logic [COORD_W-1:0] gap;
        logic [DIST_W-1:0]  dist_acc;
        bit                 flag;
        pl[0] = clamp_coord(it.point_or_low_0);
        pl[1] = clamp_coord(it.point_or_low_1);
        pl[2] = clamp_coord(it.point_or_low_2);
        pl[3] = clamp_coord(it.point_or_low_3);
        ph[0] = clamp_coord(it.upper_edge_0);
        ph[1] = clamp_coord(it.upper_edge_1);
        ph[2] = clamp_coord(it.upper_edge_2);
        ph[3] = clamp_coord(it.upper_edge_3);
        flag     = 1'b1;
        dist_acc = '0;
        res      = '0;
        case (it.operation)
            OP_CLEAR: begin
                for (int d = 0; d < DIMS; d++) begin
                    box_lo[d] = COORD_MAX;
                    box_hi[d] = '0;
                end
                return 1'b0;
            end
            OP_LOAD: begin
                for (int d = 0; d < DIMS; d++) begin
                    box_lo[d] = pl[d];
                    box_hi[d] = ph[d];
                end
                return 1'b0;
            end
            OP_GROW_POINT: begin
                for (int d = 0; d < DIMS; d++) begin
                    if (pl[d] < box_lo[d]) box_lo[d] = pl[d];
                    if (pl[d] > box_hi[d]) box_hi[d] = pl[d];
                end
                return 1'b0;
            end
            OP_GROW_BOX: begin
                for (int d = 0; d < DIMS; d++) begin
                    if (pl[d] < box_lo[d]) box_lo[d] = pl[d];
                    if (ph[d] > box_hi[d]) box_hi[d] = ph[d];
                end
                return 1'b0;
            end
            OP_CONTAINS: begin
                for (int d = 0; d < DIMS; d++)
                    if (pl[d] < box_lo[d] || pl[d] > box_hi[d]) flag = 1'b0;
            end
            OP_STRICT: begin
                for (int d = 0; d < DIMS; d++)
                    if (!(box_lo[d] < pl[d] && pl[d] < box_hi[d])) flag = 1'b0;
            end
            OP_OVERLAPS: begin
                for (int d = 0; d < DIMS; d++)
                    if (box_hi[d] < pl[d] || ph[d] < box_lo[d]) flag = 1'b0;
            end
            default: begin
                flag = 1'b0;
                for (int d = 0; d < DIMS; d++) begin
                    gap = '0;
                    if (pl[d] < box_lo[d])
                        gap = box_lo[d] - pl[d];
                    else if (pl[d] > box_hi[d])
                        gap = pl[d] - box_hi[d];
                    dist_acc += DIST_W'(gap) * DIST_W'(gap);
                end
            end
        endcase
        res.test_true        = flag;
        res.distance_squared = dist_acc;
        return 1'b1;
    endfunction

    // Lows and highs are packed with dimension 0 in the top bits.
    function automatic void add_row(input op_t op, input logic [79:0] lows,
                                    input logic [79:0] highs, input bit pinned = 1'b0,
                                    input bit t = 1'b0, input logic [DIST_W-1:0] d = '0);
        dir_row_t r;
        r.item.operation      = op;
        r.item.point_or_low_0 = lows[79:60];
        r.item.point_or_low_1 = lows[59:40];
        r.item.point_or_low_2 = lows[39:20];
        r.item.point_or_low_3 = lows[19:0];
        r.item.upper_edge_0   = highs[79:60];
        r.item.upper_edge_1   = highs[59:40];
        r.item.upper_edge_2   = highs[39:20];
        r.item.upper_edge_3   = highs[19:0];
        r.pinned              = pinned;
        r.res.test_true       = t;
        r.res.distance_squared = d;
        rows.insert(rows.size(), r);
    endfunction

    // About a third of the values land on or next to the current edges so that the
    // comparisons are exercised at their boundaries; some values are raw 20-bit noise.
    function automatic logic [COORD_W-1:0] pick_coord(input int dim, input bit hi_side);
        int sel;
        sel = $urandom_range(99);
        if (sel < 8)
            return COORD_W'($urandom);
        if (sel < 16) begin
            case ($urandom_range(3))
                0:       return '0;
                1:       return COORD_MAX;
                2:       return COORD_MAX + 1'b1;
                default: return '1;
            endcase
        end
        if (sel < 50)
            return (hi_side ? box_hi[dim] : box_lo[dim]) + COORD_W'($urandom_range(4)) - 2'd2;
        return COORD_W'($urandom_range(1000000));
    endfunction

    function automatic in_item_t random_box_item();
        in_item_t           it;
        logic [COORD_W-1:0] lo [4];
        logic [COORD_W-1:0] hi [4];
        logic [COORD_W-1:0] tmp;
        int                 r;
        r = $urandom_range(99);
        if (r < 4)       it.operation = OP_CLEAR;
        else if (r < 16) it.operation = OP_LOAD;
        else if (r < 28) it.operation = OP_GROW_POINT;
        else if (r < 38) it.operation = OP_GROW_BOX;
        else if (r < 54) it.operation = OP_CONTAINS;
        else if (r < 68) it.operation = OP_STRICT;
        else if (r < 84) it.operation = OP_OVERLAPS;
        else             it.operation = OP_DISTANCE;
        for (int d = 0; d < 4; d++) begin
            lo[d] = pick_coord(d, $urandom_range(1));
            hi[d] = pick_coord(d, $urandom_range(1));
            // Most boxes that are loaded or merged in are well formed.
            if ((it.operation == OP_LOAD || it.operation == OP_GROW_BOX)
                    && lo[d] > hi[d] && $urandom_range(9) < 8) begin
                tmp   = lo[d];
                lo[d] = hi[d];
                hi[d] = tmp;
            end
        end
        it.point_or_low_0 = lo[0];
        it.point_or_low_1 = lo[1];
        it.point_or_low_2 = lo[2];
        it.point_or_low_3 = lo[3];
        it.upper_edge_0   = hi[0];
        it.upper_edge_1   = hi[1];
        it.upper_edge_2   = hi[2];
        it.upper_edge_3   = hi[3];
        return it;
    endfunction

    task automatic offer_item(input in_item_t it, input bit pinned, input out_item_t answer);
        while ($urandom_range(99) < send_idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_item     <= it;
        pinned_ok  <= pinned;
        pinned_res <= answer;
        s_valid    <= 1'b1;
        do @(posedge aclk); while (!s_ready);
    endtask

    task automatic run_phase(input int idle_pct, input int stall_pct, input int count);
        out_item_t none;
        none = '0;
        send_idle_pct = idle_pct;
        recv_stall_pct <= stall_pct;
        repeat (count) offer_item(random_box_item(), 1'b0, none);
    endtask

    // Receiver: random stalls, plus a long hold-off whenever one is requested.
    always @(posedge aclk) begin
        if (hold_left > 0) begin
            m_ready   <= 1'b0;
            hold_left <= hold_left - 1;
        end else if (hold_requests != hold_served) begin
            hold_served <= hold_requests;
            hold_left   <= LONG_HOLD;
            m_ready     <= 1'b0;
        end else begin
            m_ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // Accepted items are predicted before results are checked in the same cycle.
    always @(posedge aclk) begin : monitor
        out_item_t want;
        out_item_t got;
        bit        answers;
        if (aresetn && s_valid && s_ready) begin
            op_seen[s_item.operation]++;
            answers = apply_box_op(s_item, want);
            if (answers) begin
                if (pinned_ok) want = pinned_res;
                pending_answers.insert(pending_answers.size(), want);
            end
        end
        if (aresetn && m_valid && m_ready) begin
            got = m_item;
            results_seen++;
            if (pending_answers.size() == 0) begin
                errors++;
                $display("%0t: result with nothing outstanding: test_true=%0b dist2=%0d",
                         $time, got.test_true, got.distance_squared);
            end else begin
                want = pending_answers.pop_front();
                if (got.test_true !== want.test_true
                        || got.distance_squared !== want.distance_squared) begin
                    errors++;
                    $display("%0t: mismatch: expected test_true=%0b dist2=%0d, got test_true=%0b dist2=%0d",
                             $time, want.test_true, want.distance_squared,
                             got.test_true, got.distance_squared);
                end
            end
        end
    end

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("%0t: timed out with %0d results outstanding", $time,
                     pending_answers.size());
            $display("Some tests failed");
            $finish;
        end
    end

    initial begin : stimulus
        in_item_t  it;
        out_item_t none;
        none = '0;
        for (int i = 0; i < 8; i++) op_seen[i] = 0;

        // Empty box straight after reset.
        add_row(OP_CONTAINS, {4{20'd0}}, {4{20'd0}}, 1'b1, 1'b0, '0);
        add_row(OP_STRICT, {4{20'd500000}}, {4{20'd0}}, 1'b1, 1'b0, '0);
        add_row(OP_OVERLAPS, {4{20'd0}}, {4{20'hFFFFF}}, 1'b1, 1'b1, '0);
        add_row(OP_DISTANCE, {4{20'd0}}, {4{20'd0}}, 1'b1, 1'b0, FAR_CORNER);
        add_row(OP_DISTANCE, {4{20'hFFFFF}}, {4{20'd0}}, 1'b1, 1'b0, FAR_CORNER);
        // Full-range box, with the upper edges saturating.
        add_row(OP_LOAD, {4{20'd0}}, {4{20'hFFFFF}});
        add_row(OP_CONTAINS, {4{20'hFFFFF}}, {4{20'd0}}, 1'b1, 1'b1, '0);
        add_row(OP_STRICT, {4{20'd1000000}}, {4{20'd0}}, 1'b1, 1'b0, '0);
        add_row(OP_STRICT, {4{20'd500000}}, {4{20'hFFFFF}}, 1'b1, 1'b1, '0);
        add_row(OP_DISTANCE, {4{20'hFFFFF}}, {4{20'd0}}, 1'b1, 1'b0, '0);
        add_row(OP_OVERLAPS, {4{20'hFFFFF}}, {4{20'hFFFFF}}, 1'b1, 1'b1, '0);
        // Growing from empty.
        add_row(OP_CLEAR, {4{20'hFFFFF}}, {4{20'hFFFFF}});
        add_row(OP_GROW_POINT, {20'd100, 20'd200, 20'd300, 20'd400}, {4{20'd7}});
        add_row(OP_GROW_POINT, {20'd900000, 20'd800000, 20'd700000, 20'd600000},
                {4{20'd0}});
        add_row(OP_CONTAINS, {20'd100, 20'd800000, 20'd500000, 20'd400}, {4{20'd0}});
        add_row(OP_STRICT, {20'd100, 20'd800000, 20'd500000, 20'd400}, {4{20'd0}});
        add_row(OP_GROW_BOX, {20'd0, 20'd250, 20'hFFFFF, 20'd5}, {20'd50, 20'd999999,
                20'd1000000, 20'd650000});
        add_row(OP_OVERLAPS, {20'd950000, 20'd0, 20'd0, 20'd0}, {4{20'd1000000}});
        add_row(OP_DISTANCE, {20'd1000000, 20'd0, 20'd123456, 20'hFFFFF}, {4{20'd0}});
        // Inverted box: holds no point but still meets the full range.
        add_row(OP_LOAD, {4{20'd700000}}, {4{20'd300000}});
        add_row(OP_CONTAINS, {4{20'd500000}}, {4{20'd0}}, 1'b1, 1'b0, '0);
        add_row(OP_OVERLAPS, {4{20'd0}}, {4{20'd1000000}}, 1'b1, 1'b1, '0);
        add_row(OP_DISTANCE, {20'd500000, 20'd0, 20'd1000000, 20'd650000}, {4{20'd0}});
        add_row(OP_CLEAR, {4{20'd0}}, {4{20'd0}});
        add_row(OP_DISTANCE, {4{20'd1000000}}, {4{20'd0}}, 1'b1, 1'b0, FAR_CORNER);

        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        foreach (rows[i]) offer_item(rows[i].item, rows[i].pinned, rows[i].res);

        run_phase(0, 0, 150);
        run_phase(84, 0, 150);
        run_phase(0, 84, 150);
        run_phase(24, 24, 150);

        // Back-to-back queries against a long output hold-off, so the block backs up.
        send_idle_pct = 0;
        recv_stall_pct <= 0;
        hold_requests <= hold_requests + 1;
        repeat (40) begin
            it = random_box_item();
            it.operation = op_t'(OP_CONTAINS + $urandom_range(3));
            offer_item(it, 1'b0, none);
        end
        s_valid <= 1'b0;

        while (pending_answers.size() != 0) @(posedge aclk);
        repeat (SETTLE) @(posedge aclk);

        $display("Drove %0d directed and %0d random items; ops clear/load/grow/grow-box: %0d/%0d/%0d/%0d,",
                 rows.size(), 640, op_seen[OP_CLEAR], op_seen[OP_LOAD],
                 op_seen[OP_GROW_POINT], op_seen[OP_GROW_BOX]);
        $display("queries contains/strict/overlap/distance: %0d/%0d/%0d/%0d; %0d results checked.",
                 op_seen[OP_CONTAINS], op_seen[OP_STRICT], op_seen[OP_OVERLAPS],
                 op_seen[OP_DISTANCE], results_seen);
        if (errors == 0 && pending_answers.size() == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule
